// ===== design/t16x_pkg.sv =====
`timescale 1ns / 1ps
package t16x_pkg;
	localparam int WordW = 16;

	typedef logic [WordW-1:0] word_t;
	typedef logic [4:0] func_t;
	typedef logic [1:0] fault_t;

	localparam func_t OP_MOVL  = 5'd0;
	localparam func_t OP_MOVR  = 5'd1;
	localparam func_t OP_ADDL  = 5'd2;
	localparam func_t OP_ADDR  = 5'd3;
	localparam func_t OP_SUBL  = 5'd4;
	localparam func_t OP_SUBR  = 5'd5;
	localparam func_t OP_MULL  = 5'd6;
	localparam func_t OP_MULR  = 5'd7;
	localparam func_t OP_DIVL  = 5'd8;
	localparam func_t OP_DIVR  = 5'd9;
	localparam func_t OP_CMPL  = 5'd10;
	localparam func_t OP_CMPR  = 5'd11;
	localparam func_t OP_JMP   = 5'd12;
	localparam func_t OP_JZ    = 5'd13;
	localparam func_t OP_JNZ   = 5'd14;
	localparam func_t OP_JL    = 5'd15;
	localparam func_t OP_JLE   = 5'd16;
	localparam func_t OP_JG    = 5'd17;
	localparam func_t OP_JGE   = 5'd18;
	localparam func_t OP_CALL  = 5'd19;
	localparam func_t OP_RET   = 5'd20;
	localparam func_t OP_PUSHL = 5'd21;
	localparam func_t OP_PUSHR = 5'd22;
	localparam func_t OP_POPR  = 5'd23;
	localparam func_t OP_HLT   = 5'd24;

	localparam logic [2:0] KIND_MOV = 3'd0;
	localparam logic [2:0] KIND_ADD = 3'd1;
	localparam logic [2:0] KIND_SUB = 3'd2;
	localparam logic [2:0] KIND_MUL = 3'd3;
	localparam logic [2:0] KIND_DIV = 3'd4;

	localparam fault_t FAULT_NONE = 2'd0;
	localparam fault_t FAULT_REG  = 2'd1;
	localparam fault_t FAULT_DIV0 = 2'd2;
	localparam fault_t FAULT_OP   = 2'd3;

	localparam logic [WordW-1:0] NumRegCodes = 16'd12;
	localparam logic [WordW-1:0] HighMask = 16'hFF00;
	localparam logic [WordW-1:0] LowMask  = 16'h00FF;

	typedef struct packed {
		logic start;
		logic commit;
		logic div_start;
	} ctl_cmd_t;

	typedef struct packed {
		logic is_div;
		logic div_done;
	} ctl_sts_t;

	typedef struct packed {
		word_t  next_ip;
		word_t  condition_value;
		logic   halted;
		fault_t fault;
	} result_t;
endpackage

// ===== design/t16x_if.sv =====
`timescale 1ns / 1ps
interface t16x_in_if;
	logic valid;
	logic ready;
	logic [4:0] func;
	logic [15:0] first_operand;
	logic [15:0] second_operand;
	modport source (output valid, func, first_operand, second_operand, input ready);
	modport sink (input valid, func, first_operand, second_operand, output ready);
endinterface

interface t16x_out_if;
	logic valid;
	logic ready;
	logic [15:0] next_ip;
	logic signed [15:0] condition_value;
	logic halted;
	logic [1:0] fault;
	modport source (output valid, next_ip, condition_value, halted, fault, input ready);
	modport sink (input valid, next_ip, condition_value, halted, fault, output ready);
endinterface

// ===== design/t16x_ram.sv =====
`timescale 1ns / 1ps
module t16x_ram #(
	parameter int Width = 16,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ===== design/t16x_div.sv =====
`timescale 1ns / 1ps
module t16x_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  t16x_pkg::word_t    dividend,
	input  t16x_pkg::word_t    divisor,
	output logic               done,
	output t16x_pkg::word_t    quotient
);
	import t16x_pkg::*;

	logic [15:0] a_q, q_q, b_q;
	logic [16:0] rem_q;
	logic [4:0]  cnt_q;
	logic        busy_q, neg_q;
	logic [16:0] trial;
	logic [15:0] qmag;

	assign trial = {rem_q[15:0], a_q[15]} - {1'b0, b_q};
	assign qmag = q_q;
	assign quotient = neg_q ? (~qmag + 16'd1) : qmag;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 5'd16;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= dividend[15] ? (~dividend + 16'd1) : dividend;
			b_q <= divisor[15] ? (~divisor + 16'd1) : divisor;
			neg_q <= dividend[15] ^ divisor[15];
			rem_q <= '0;
			q_q <= '0;
		end else if (busy_q) begin
			a_q <= {a_q[14:0], 1'b0};
			if (!trial[16]) begin
				rem_q <= trial;
				q_q <= {q_q[14:0], 1'b1};
			end else begin
				rem_q <= {rem_q[15:0], a_q[15]};
				q_q <= {q_q[14:0], 1'b0};
			end
		end
	end
endmodule

// ===== design/t16x_ctrl.sv =====
`timescale 1ns / 1ps
module t16x_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  t16x_pkg::ctl_sts_t  sts,
	output t16x_pkg::ctl_cmd_t  cmd
);
	import t16x_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EXEC = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0] state_q;

	assign in_ready = (state_q == ST_IDLE) || (state_q == ST_DONE && out_ready);
	assign out_valid = (state_q == ST_DONE);

	always_comb begin
		cmd.start = in_valid && in_ready;
		cmd.div_start = (state_q == ST_EXEC) && sts.is_div;
		cmd.commit = ((state_q == ST_EXEC) && !sts.is_div) || (state_q == ST_DIV && sts.div_done);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: if (in_valid) state_q <= ST_EXEC;
				ST_EXEC: state_q <= sts.is_div ? ST_DIV : ST_DONE;
				ST_DIV:  if (sts.div_done) state_q <= ST_DONE;
				ST_DONE: begin
					if (out_ready) state_q <= in_valid ? ST_EXEC : ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// ===== design/t16x_dp.sv =====
`timescale 1ns / 1ps
module t16x_dp #(
	parameter int DataStackDepth = 16,
	parameter int ReturnStackDepth = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  t16x_pkg::ctl_cmd_t  cmd,
	output t16x_pkg::ctl_sts_t  sts,
	input  t16x_pkg::func_t     func,
	input  t16x_pkg::word_t     first_operand,
	input  t16x_pkg::word_t     second_operand,
	output t16x_pkg::result_t   res
);
	import t16x_pkg::*;

	localparam int DsW = $clog2(DataStackDepth);
	localparam int RsW = $clog2(ReturnStackDepth);

	word_t  gr_q [4];
	word_t  rr_q, ip_q;
	logic   halt_q;
	fault_t fault_q;
	logic [DsW-1:0] dsp_q;
	logic [RsW-1:0] rsp_q;
	logic [DataStackDepth-1:0]   dsv_q;
	logic [ReturnStackDepth-1:0] rsv_q;
	func_t  op_q;
	word_t  a_q, b_q;

	// stack pointer steps with wrap
	logic [DsW-1:0] dsp_inc, dsp_dec;
	logic [RsW-1:0] rsp_inc, rsp_dec;
	assign dsp_inc = (dsp_q == DsW'(DataStackDepth-1)) ? '0 : dsp_q + 1'b1;
	assign dsp_dec = (dsp_q == '0) ? DsW'(DataStackDepth-1) : dsp_q - 1'b1;
	assign rsp_inc = (rsp_q == RsW'(ReturnStackDepth-1)) ? '0 : rsp_q + 1'b1;
	assign rsp_dec = (rsp_q == '0) ? RsW'(ReturnStackDepth-1) : rsp_q - 1'b1;

	function automatic word_t rd(input word_t w, input logic [1:0] part);
		case (part)
			2'd0: rd = w;
			2'd1: rd = {8'd0, w[15:8]};
			default: rd = w & LowMask;
		endcase
	endfunction

	function automatic word_t wr(input word_t w, input logic [1:0] part, input word_t v);
		case (part)
			2'd0: wr = v;
			2'd1: wr = (w & LowMask) | {v[7:0], 8'd0};
			default: wr = (w & HighMask) | (v & LowMask);
		endcase
	endfunction

	// {index, part} of a register code: index = code/3, part = code%3
	function automatic logic [3:0] reg_sel(input logic [3:0] code);
		case (code)
			4'd0:    reg_sel = 4'b00_00;
			4'd1:    reg_sel = 4'b00_01;
			4'd2:    reg_sel = 4'b00_10;
			4'd3:    reg_sel = 4'b01_00;
			4'd4:    reg_sel = 4'b01_01;
			4'd5:    reg_sel = 4'b01_10;
			4'd6:    reg_sel = 4'b10_00;
			4'd7:    reg_sel = 4'b10_01;
			4'd8:    reg_sel = 4'b10_10;
			4'd9:    reg_sel = 4'b11_00;
			4'd10:   reg_sel = 4'b11_01;
			4'd11:   reg_sel = 4'b11_10;
			default: reg_sel = 4'b00_00;
		endcase
	endfunction

	logic [1:0] a_idx, a_part, b_idx, b_part;
	logic a_ok, b_ok;
	always_comb begin
		a_ok = a_q < NumRegCodes;
		b_ok = b_q < NumRegCodes;
		{a_idx, a_part} = reg_sel(a_q[3:0]);
		{b_idx, b_part} = reg_sel(b_q[3:0]);
	end

	word_t x, y;
	assign x = rd(gr_q[a_idx], a_part);
	assign y = op_q[0] ? rd(gr_q[b_idx], b_part) : b_q;

	logic [2:0] kind;
	assign kind = op_q[3:1];
	logic is_alu;
	assign is_alu = op_q <= OP_CMPR;
	logic alu_fault;
	assign alu_fault = !a_ok || (op_q[0] && !b_ok);

	assign sts.is_div = is_alu && kind == KIND_DIV && !alu_fault && y != '0;

	word_t quot;
	t16x_div u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.dividend(x), .divisor(y), .done(sts.div_done), .quotient(quot)
	);

	logic [31:0] prod;
	assign prod = 32'(x) * 32'(y);

	word_t alu_res;
	always_comb begin
		case (kind)
			KIND_MOV: alu_res = y;
			KIND_ADD: alu_res = x + y;
			KIND_MUL: alu_res = prod[15:0];
			KIND_DIV: alu_res = quot;
			default:  alu_res = x - y;
		endcase
	end

	// stacks: read address is current pointer, data settles before commit
	logic ds_we, rs_we;
	word_t ds_wd, ds_rd, rs_rd;
	logic ds_rv_q, rs_rv_q;
	t16x_ram #(.Width(16), .Depth(DataStackDepth)) u_ds (
		.clk(clk), .we(ds_we), .waddr(dsp_inc), .wdata(ds_wd), .raddr(dsp_q), .rdata(ds_rd)
	);
	t16x_ram #(.Width(16), .Depth(ReturnStackDepth)) u_rs (
		.clk(clk), .we(rs_we), .waddr(rsp_inc), .wdata(ip_q), .raddr(rsp_q), .rdata(rs_rd)
	);
	logic pushr_ok, popr_ok;
	assign pushr_ok = op_q == OP_PUSHR && a_ok;
	assign popr_ok = op_q == OP_POPR && a_ok;
	assign ds_we = cmd.commit && (op_q == OP_PUSHL || pushr_ok);
	assign ds_wd = (op_q == OP_PUSHL) ? a_q : x;
	assign rs_we = cmd.commit && op_q == OP_CALL;

	word_t pop_v, ret_v;
	assign pop_v = ds_rv_q ? ds_rd : '0;
	assign ret_v = rs_rv_q ? rs_rd : '0;

	logic take;
	logic sr;
	assign sr = rr_q[15];
	always_comb begin
		case (op_q)
			OP_JMP: take = 1'b1;
			OP_JZ:  take = rr_q == '0;
			OP_JNZ: take = rr_q != '0;
			OP_JL:  take = sr;
			OP_JLE: take = sr || rr_q == '0;
			OP_JG:  take = !sr && rr_q != '0;
			OP_JGE: take = !sr;
			default: take = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			op_q <= func;
			a_q <= first_operand;
			b_q <= second_operand;
		end
		ds_rv_q <= dsv_q[dsp_q];
		rs_rv_q <= rsv_q[rsp_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) gr_q[i] <= '0;
			rr_q <= '0;
			ip_q <= '0;
			halt_q <= 1'b0;
			fault_q <= FAULT_NONE;
			dsp_q <= '0;
			rsp_q <= '0;
			dsv_q <= '0;
			rsv_q <= '0;
		end else if (cmd.commit) begin
			fault_q <= FAULT_NONE;
			ip_q <= ip_q + 16'd1;
			if (is_alu) begin
				if (alu_fault) begin
					fault_q <= FAULT_REG;
				end else if (kind == KIND_DIV && y == '0) begin
					fault_q <= FAULT_DIV0;
				end else begin
					if (kind <= KIND_DIV) gr_q[a_idx] <= wr(gr_q[a_idx], a_part, alu_res);
					if (kind != KIND_MOV) rr_q <= alu_res;
				end
			end else if (op_q <= OP_JGE) begin
				if (take) ip_q <= a_q + 16'd1;
			end else begin
				case (op_q)
					OP_CALL: begin
						rsp_q <= rsp_inc;
						rsv_q[rsp_inc] <= 1'b1;
						ip_q <= a_q + 16'd1;
					end
					OP_RET: begin
						ip_q <= ret_v + 16'd1;
						rsp_q <= rsp_dec;
					end
					OP_PUSHL: begin
						dsp_q <= dsp_inc;
						dsv_q[dsp_inc] <= 1'b1;
					end
					OP_PUSHR: begin
						if (pushr_ok) begin
							dsp_q <= dsp_inc;
							dsv_q[dsp_inc] <= 1'b1;
						end else fault_q <= FAULT_REG;
					end
					OP_POPR: begin
						if (popr_ok) begin
							gr_q[a_idx] <= wr(gr_q[a_idx], a_part, pop_v);
							dsp_q <= dsp_dec;
						end else fault_q <= FAULT_REG;
					end
					OP_HLT: halt_q <= 1'b1;
					default: fault_q <= FAULT_OP;
				endcase
			end
		end
	end

	assign res.next_ip = ip_q;
	assign res.condition_value = rr_q;
	assign res.halted = halt_q;
	assign res.fault = fault_q;
endmodule

// ===== design/toy16_instruction_execute_core.sv =====
`timescale 1ns / 1ps
// Executes one toy16 instruction per input transaction and returns the
// machine state after it. Instructions go through the execute state to
// result valid; divides also wait in the divide state for the radix-2
// restoring divider, one quotient bit per cycle. One instruction is in
// flight at a time; the next is accepted in the cycle the result is taken.
module toy16_instruction_execute_core #(
	parameter int DATA_STACK_DEPTH = 16,
	parameter int RETURN_STACK_DEPTH = 16
) (
	input logic clk,
	input logic arst_n,
	t16x_in_if.sink    in_ch,
	t16x_out_if.source out_ch
);
	import t16x_pkg::*;

	ctl_cmd_t cmd;
	ctl_sts_t sts;
	result_t  res;

	t16x_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.sts(sts), .cmd(cmd)
	);

	t16x_dp #(
		.DataStackDepth(DATA_STACK_DEPTH), .ReturnStackDepth(RETURN_STACK_DEPTH)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.func(in_ch.func), .first_operand(in_ch.first_operand),
		.second_operand(in_ch.second_operand), .res(res)
	);

	assign out_ch.next_ip = res.next_ip;
	assign out_ch.condition_value = res.condition_value;
	assign out_ch.halted = res.halted;
	assign out_ch.fault = res.fault;
endmodule

// ===== tb/toy16_instruction_execute_core_test.sv =====
`timescale 1ns / 1ps
import t16x_pkg::*;

typedef struct {
	logic [15:0] next_ip;
	logic [15:0] condition_value;
	logic        halted;
	logic [1:0]  fault;
} exec_result_t;

class exec_scoreboard;
	logic [15:0] regs [4];
	logic [15:0] acc;
	logic [15:0] ip;
	logic [15:0] dstack [16];
	logic [3:0]  dsp;
	logic [15:0] rstack [16];
	logic [3:0]  rsp;
	logic        halt;
	exec_result_t pending [$];
	int mismatches;

	function new();
		for (int i = 0; i < 4; i++) regs[i] = '0;
		for (int i = 0; i < 16; i++) begin
			dstack[i] = '0;
			rstack[i] = '0;
		end
		acc = '0;
		ip = '0;
		dsp = '0;
		rsp = '0;
		halt = 1'b0;
		mismatches = 0;
	endfunction

	function logic [15:0] rd(logic [15:0] code);
		logic [15:0] w;
		w = regs[(code / 3) & 3];
		case (code % 3)
			0: return w;
			1: return {8'h00, w[15:8]};
			default: return {8'h00, w[7:0]};
		endcase
	endfunction

	function void wr(logic [15:0] code, logic [15:0] v);
		int i;
		i = (code / 3) & 3;
		case (code % 3)
			0: regs[i] = v;
			1: regs[i] = (regs[i] & LowMask) | {v[7:0], 8'h00};
			default: regs[i] = (regs[i] & HighMask) | {8'h00, v[7:0]};
		endcase
	endfunction

	function void note_instruction(logic [4:0] op, logic [15:0] a, logic [15:0] b);
		exec_result_t e;
		logic [1:0] flt;
		logic [15:0] x, y, res;
		logic signed [15:0] r;
		logic [2:0] kind;
		logic take;
		flt = FAULT_NONE;
		r = acc;
		res = '0;
		if (op <= OP_CMPR) begin
			kind = op[3:1];
			if (a >= NumRegCodes || (op[0] && b >= NumRegCodes)) begin
				flt = FAULT_REG;
			end else begin
				y = op[0] ? rd(b) : b;
				x = rd(a);
				case (kind)
					KIND_MOV: res = y;
					KIND_ADD: res = x + y;
					KIND_SUB: res = x - y;
					KIND_MUL: res = x * y;
					KIND_DIV: begin
						if (y == 0) flt = FAULT_DIV0;
						else res = $signed(x) / $signed(y);
					end
					default: res = x - y;
				endcase
				if (flt == FAULT_NONE) begin
					if (kind <= KIND_DIV) wr(a, res);
					if (kind >= KIND_ADD) acc = res;
				end
			end
		end else if (op <= OP_JGE) begin
			case (op)
				OP_JMP: take = 1'b1;
				OP_JZ: take = (r == 0);
				OP_JNZ: take = (r != 0);
				OP_JL: take = (r < 0);
				OP_JLE: take = (r <= 0);
				OP_JG: take = (r > 0);
				default: take = (r >= 0);
			endcase
			if (take) ip = a;
		end else if (op == OP_CALL) begin
			rsp++;
			rstack[rsp] = ip;
			ip = a;
		end else if (op == OP_RET) begin
			ip = rstack[rsp];
			rsp--;
		end else if (op == OP_PUSHL) begin
			dsp++;
			dstack[dsp] = a;
		end else if (op == OP_PUSHR) begin
			if (a >= NumRegCodes) flt = FAULT_REG;
			else begin
				dsp++;
				dstack[dsp] = rd(a);
			end
		end else if (op == OP_POPR) begin
			if (a >= NumRegCodes) flt = FAULT_REG;
			else begin
				wr(a, dstack[dsp]);
				dsp--;
			end
		end else if (op == OP_HLT) begin
			halt = 1'b1;
		end else begin
			flt = FAULT_OP;
		end
		ip = ip + 1;
		e.next_ip = ip;
		e.condition_value = acc;
		e.halted = halt;
		e.fault = flt;
		pending.push_back(e);
	endfunction

	function void check_result(exec_result_t got);
		exec_result_t e;
		if (pending.size() == 0) begin
			mismatches++;
			if (mismatches <= 10) $display("unexpected result ip=%h", got.next_ip);
			return;
		end
		e = pending.pop_front();
		if (got.next_ip !== e.next_ip || got.condition_value !== e.condition_value ||
				got.halted !== e.halted || got.fault !== e.fault) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch: exp ip=%h cv=%h h=%b f=%0d got ip=%h cv=%h h=%b f=%0d",
					e.next_ip, e.condition_value, e.halted, e.fault,
					got.next_ip, got.condition_value, got.halted, got.fault);
		end
	endfunction
endclass

module toy16_instruction_execute_core_test;
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	t16x_in_if in_ch();
	t16x_out_if out_ch();
	exec_scoreboard sb;
	int src_idle_pct = 0;
	int snk_stall_pct = 0;
	int cycles = 0;
	bit done = 1'b0;

	toy16_instruction_execute_core uut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		in_ch.valid = 1'b0;
		in_ch.func = '0;
		in_ch.first_operand = '0;
		in_ch.second_operand = '0;
		out_ch.ready = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		exec_result_t got;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got.next_ip = out_ch.next_ip;
			got.condition_value = out_ch.condition_value;
			got.halted = out_ch.halted;
			got.fault = out_ch.fault;
			sb.check_result(got);
		end
		out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
	end

	task automatic send_instruction(logic [4:0] op, logic [15:0] a, logic [15:0] b);
		while ($urandom_range(99) < src_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.func <= op;
		in_ch.first_operand <= a;
		in_ch.second_operand <= b;
		do @(posedge clk); while (!in_ch.ready);
		sb.note_instruction(op, a, b);
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
	endtask

	function automatic logic [15:0] reg_code();
		return ($urandom_range(15) == 0) ? 16'($urandom) : 16'($urandom_range(11));
	endfunction

	function automatic logic [15:0] lit_word();
		case ($urandom_range(5))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'h8000;
			3: return 16'h7FFF;
			4: return 16'($urandom_range(7));
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic random_instruction();
		logic [4:0] op;
		logic [15:0] a, b;
		op = ($urandom_range(30) == 0) ? 5'($urandom_range(25, 31)) : 5'($urandom_range(24));
		a = reg_code();
		b = (op <= OP_CMPR && op[0]) ? reg_code() : lit_word();
		if (op >= OP_JMP && op <= OP_CALL) a = 16'($urandom);
		if (op == OP_PUSHL) a = lit_word();
		send_instruction(op, a, b);
	endtask

	initial begin
		sb = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_instruction(OP_MOVL, 16'd0, 16'h8000);
		send_instruction(OP_DIVL, 16'd0, 16'hFFFF);
		send_instruction(OP_DIVL, 16'd0, 16'd0);
		send_instruction(OP_MOVL, 16'd4, 16'hABCD);
		send_instruction(OP_MOVL, 16'd5, 16'h1234);
		send_instruction(OP_MOVR, 16'd9, 16'd4);
		send_instruction(OP_ADDR, 16'd11, 16'd5);
		send_instruction(OP_ADDL, 16'd3, 16'hFFFF);
		send_instruction(OP_SUBL, 16'd6, 16'h0001);
		send_instruction(OP_MULR, 16'd0, 16'd3);
		send_instruction(OP_DIVR, 16'd3, 16'd0);
		send_instruction(OP_CMPL, 16'd0, 16'h7FFF);
		send_instruction(OP_CMPR, 16'd12, 16'd0);
		send_instruction(OP_CMPR, 16'd0, 16'hFFFF);
		for (int j = OP_JMP; j <= OP_JGE; j++) send_instruction(5'(j), 16'hFFFF, 16'd0);
		send_instruction(OP_CALL, 16'h0100, 16'd0);
		send_instruction(OP_RET, 16'd0, 16'd0);
		send_instruction(OP_PUSHL, 16'hFFFF, 16'd0);
		send_instruction(OP_PUSHR, 16'd4, 16'd0);
		send_instruction(OP_POPR, 16'd7, 16'd0);
		send_instruction(OP_HLT, 16'd0, 16'd0);
		send_instruction(5'd31, 16'd0, 16'd0);
		for (int p = 0; p < 5; p++) begin
			case (p)
				0: begin src_idle_pct = 0; snk_stall_pct = 0; end
				1: begin src_idle_pct = 78; snk_stall_pct = 0; end
				2: begin src_idle_pct = 0; snk_stall_pct = 78; end
				3: begin src_idle_pct = 33; snk_stall_pct = 33; end
				default: begin src_idle_pct = 0; snk_stall_pct = 0; end
			endcase
			for (int i = 0; i < 345; i++) random_instruction();
			if (p == 2) drain();
		end
		snk_stall_pct = 0;
		drain();
		repeat (40) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule
